// File: rtl/core/csrf_pkg.sv
// ----------------------------------------------------------------------------
// csrf_pkg
// Shared constants, widths, register indexes and tap geometry for the
// center-surround ring filter.
// ----------------------------------------------------------------------------
package csrf_pkg;

    // Window geometry
    localparam int RADIUS    = 3;
    localparam int MAX_WIDTH = 1024;
    localparam int SPAN      = 2 * RADIUS + 1;
    localparam int LINES     = 2 * RADIUS;
    localparam int AREA      = SPAN * SPAN;

    // Fixed field widths
    localparam int PIX_W      = 8;
    localparam int IW_W       = 11;
    localparam int IH_W       = 12;
    localparam int IR_W       = 2;
    localparam int WGT_W      = 16;
    localparam int ROW_W      = 12;
    localparam int CCOL_W     = 10;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int RIN2_W     = 2 * IR_W;

    // Derived widths
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WCMP_W   = (COL_W + 1 > IW_W) ? COL_W + 1 : IW_W;
    localparam int LINE_W   = LINES * PIX_W;
    localparam int ROWSUM_W = PIX_W + $clog2(SPAN);
    localparam int TOT_W    = PIX_W + $clog2(AREA);
    localparam int PROD_W   = WGT_W + TOT_W + 1;
    localparam int SUM_W    = PROD_W + 1;
    localparam int ABS_W    = SUM_W - 1;

    // Reciprocal of the window area; the truncated quotient is off by at most one.
    localparam int RECIP_SH                   = ABS_W;
    localparam longint unsigned RECIP_FULL    = (64'd1 << RECIP_SH) / AREA;
    localparam int RECIP_W                    = RECIP_SH - $clog2(AREA) + 1;
    localparam logic [RECIP_W-1:0] RECIP_K    = RECIP_W'(RECIP_FULL);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH     = 3'd0,
        CFG_IMAGE_HEIGHT    = 3'd1,
        CFG_INNER_RADIUS    = 3'd2,
        CFG_CENTER_WEIGHT   = 3'd3,
        CFG_SURROUND_WEIGHT = 3'd4
    } t_cfg_reg;

    // Reset values of the configuration registers
    localparam logic [IW_W-1:0]         RST_IMAGE_WIDTH     = IW_W'(640);
    localparam logic [IH_W-1:0]         RST_IMAGE_HEIGHT    = IH_W'(480);
    localparam logic [IR_W-1:0]         RST_INNER_RADIUS    = IR_W'(1);
    localparam logic signed [WGT_W-1:0] RST_CENTER_WEIGHT   = -16'sd256;
    localparam logic signed [WGT_W-1:0] RST_SURROUND_WEIGHT = 16'sd1536;

    // Squared distance of window tap (dy, dx) from the window center.
    function automatic int unsigned tap_dist2(input int unsigned dy, input int unsigned dx);
        int oy;
        int ox;
        oy = int'(dy) - RADIUS;
        ox = int'(dx) - RADIUS;
        return $unsigned(oy * oy + ox * ox);
    endfunction

endpackage

// File: rtl/core/center_surround_ring_filter_core.sv
// ----------------------------------------------------------------------------
// center_surround_ring_filter_core
// A result passes every stage register in turn; stage 9 holds the output register.
// Throughput: one pixel per cycle while the output is not stalled; the line store
// takes one read and one write per cycle, with same-column write-to-read forwarding.
// Reset: counters, valids and configuration return to defaults; the line store
// and window are not cleared.
// ----------------------------------------------------------------------------
module center_surround_ring_filter_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [csrf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [csrf_pkg::CFG_DATA_W-1:0]    i_cfg_data,

    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [csrf_pkg::PIX_W-1:0]         i_pixel,
    input  logic                               i_first_of_frame,

    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [csrf_pkg::OUT_W-1:0]  o_filtered_value,
    output logic [csrf_pkg::ROW_W-1:0]         o_center_row,
    output logic [csrf_pkg::CCOL_W-1:0]        o_center_col,
    output logic                               o_last_of_frame
);

    localparam int SPAN     = csrf_pkg::SPAN;
    localparam int LINES    = csrf_pkg::LINES;
    localparam int PIX_W    = csrf_pkg::PIX_W;
    localparam int COL_W    = csrf_pkg::COL_W;
    localparam int ROW_W    = csrf_pkg::ROW_W;
    localparam int CCOL_W   = csrf_pkg::CCOL_W;
    localparam int WCMP_W   = csrf_pkg::WCMP_W;
    localparam int LINE_W   = csrf_pkg::LINE_W;
    localparam int ROWSUM_W = csrf_pkg::ROWSUM_W;
    localparam int TOT_W    = csrf_pkg::TOT_W;
    localparam int PROD_W   = csrf_pkg::PROD_W;
    localparam int SUM_W    = csrf_pkg::SUM_W;
    localparam int ABS_W    = csrf_pkg::ABS_W;
    localparam int RECIP_W  = csrf_pkg::RECIP_W;
    localparam int MUL_W    = ABS_W + RECIP_W;
    localparam int OUT_W    = csrf_pkg::OUT_W;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [csrf_pkg::IW_W-1:0]          r_image_width;
    logic [csrf_pkg::IH_W-1:0]          r_image_height;
    logic [csrf_pkg::IR_W-1:0]          r_inner_radius;
    logic signed [csrf_pkg::WGT_W-1:0]  r_center_weight;
    logic signed [csrf_pkg::WGT_W-1:0]  r_surround_weight;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width     <= csrf_pkg::RST_IMAGE_WIDTH;
            r_image_height    <= csrf_pkg::RST_IMAGE_HEIGHT;
            r_inner_radius    <= csrf_pkg::RST_INNER_RADIUS;
            r_center_weight   <= csrf_pkg::RST_CENTER_WEIGHT;
            r_surround_weight <= csrf_pkg::RST_SURROUND_WEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                csrf_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[csrf_pkg::IW_W-1:0];
                end
                csrf_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[csrf_pkg::IH_W-1:0];
                end
                csrf_pkg::CFG_INNER_RADIUS: begin
                    r_inner_radius <= i_cfg_data[csrf_pkg::IR_W-1:0];
                end
                csrf_pkg::CFG_CENTER_WEIGHT: begin
                    r_center_weight <= $signed(i_cfg_data[csrf_pkg::WGT_W-1:0]);
                end
                csrf_pkg::CFG_SURROUND_WEIGHT: begin
                    r_surround_weight <= $signed(i_cfg_data[csrf_pkg::WGT_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;
    logic r_s6_valid, r_s7_valid, r_s8_valid, r_s9_valid;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8, rdy9;
    logic in_accept;

    assign rdy9 = !r_s9_valid || !i_out_stall;
    assign rdy8 = !r_s8_valid || rdy9;
    assign rdy7 = !r_s7_valid || rdy8;
    assign rdy6 = !r_s6_valid || rdy7;
    assign rdy5 = !r_s5_valid || rdy6;
    assign rdy4 = !r_s4_valid || rdy5;
    assign rdy3 = !r_s3_valid || rdy4;
    assign rdy2 = !r_s2_valid || rdy3;
    assign rdy1 = !r_s1_valid || rdy2;

    assign o_in_stall = !rdy1;
    assign in_accept  = i_in_valid && rdy1;

    // ------------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------------
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  n_col;
    logic [WCMP_W-1:0] width_eff;
    logic [WCMP_W-1:0] col_p1;
    logic [ROW_W:0]    row_p1;
    logic              col_wrap;
    logic              row_wrap;
    logic              cur_emit;
    logic              cur_last;

    always_comb begin
        cur_row   = i_first_of_frame ? '0 : r_row;
        cur_col   = i_first_of_frame ? '0 : r_col;
        width_eff = (WCMP_W'(r_image_width) > WCMP_W'(csrf_pkg::MAX_WIDTH))
                  ? WCMP_W'(csrf_pkg::MAX_WIDTH) : WCMP_W'(r_image_width);
        col_p1    = WCMP_W'(cur_col) + WCMP_W'(1);
        row_p1    = {1'b0, cur_row} + (ROW_W+1)'(1);
        col_wrap  = col_p1 >= width_eff;
        row_wrap  = row_p1 >= (ROW_W+1)'(r_image_height);
        cur_emit  = (cur_row >= ROW_W'(LINES)) && (cur_col >= COL_W'(LINES));
        cur_last  = col_wrap && row_wrap;
        if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : row_p1[ROW_W-1:0];
        end else begin
            n_col = cur_col + COL_W'(1);
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: line store read, column assembly and write-back
    // ------------------------------------------------------------------------
    logic [LINE_W-1:0] line_mem [csrf_pkg::MAX_WIDTH];
    logic [LINE_W-1:0] r_rd_data;
    logic [LINE_W-1:0] r_fwd_data;
    logic              r_fwd;
    logic [PIX_W-1:0]  r_s1_pixel;
    logic [COL_W-1:0]  r_s1_addr;
    logic              r_s1_emit;
    logic [ROW_W-1:0]  r_s1_crow;
    logic [CCOL_W-1:0] r_s1_ccol;
    logic              r_s1_last;
    logic              s1_leave;
    logic [LINE_W-1:0] col_word;
    logic [LINE_W-1:0] wr_word;

    assign s1_leave = r_s1_valid && rdy2;
    assign col_word = r_fwd ? r_fwd_data : r_rd_data;
    // Every line moves up by one row; the new pixel enters the bottom line.
    assign wr_word  = {r_s1_pixel, col_word[LINE_W-1:PIX_W]};

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_data <= line_mem[cur_col];
        end
        if (s1_leave) begin
            line_mem[r_s1_addr] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (rdy1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // A request that reads the column being written in the same cycle takes
    // the written word instead of the stale memory data.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fwd      <= s1_leave && (cur_col == r_s1_addr);
            r_fwd_data <= wr_word;
            r_s1_pixel <= i_pixel;
            r_s1_addr  <= cur_col;
            r_s1_emit  <= cur_emit;
            r_s1_crow  <= cur_row - ROW_W'(csrf_pkg::RADIUS);
            r_s1_ccol  <= CCOL_W'(cur_col - COL_W'(csrf_pkg::RADIUS));
            r_s1_last  <= cur_last;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: window shift register
    // ------------------------------------------------------------------------
    logic [PIX_W-1:0]  r_win [SPAN][SPAN];
    logic              r_s2_emit;
    logic [ROW_W-1:0]  r_s2_crow;
    logic [CCOL_W-1:0] r_s2_ccol;
    logic              r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (rdy2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_leave) begin
            for (int dy = 0; dy < SPAN; dy++) begin
                for (int dx = 0; dx < SPAN - 1; dx++) begin
                    r_win[dy][dx] <= r_win[dy][dx+1];
                end
                if (dy < LINES) begin
                    r_win[dy][SPAN-1] <= col_word[dy*PIX_W +: PIX_W];
                end else begin
                    r_win[dy][SPAN-1] <= r_s1_pixel;
                end
            end
            r_s2_emit <= r_s1_emit;
            r_s2_crow <= r_s1_crow;
            r_s2_ccol <= r_s1_ccol;
            r_s2_last <= r_s1_last;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: per-row sums of disc and ring taps
    // ------------------------------------------------------------------------
    logic [csrf_pkg::RIN2_W-1:0] rin2;
    logic [ROWSUM_W-1:0]         row_csum [SPAN];
    logic [ROWSUM_W-1:0]         row_rsum [SPAN];
    logic [ROWSUM_W-1:0]         r_s3_csum [SPAN];
    logic [ROWSUM_W-1:0]         r_s3_rsum [SPAN];
    logic [ROW_W-1:0]            r_s3_crow;
    logic [CCOL_W-1:0]           r_s3_ccol;
    logic                        r_s3_last;

    assign rin2 = csrf_pkg::RIN2_W'(r_inner_radius) * csrf_pkg::RIN2_W'(r_inner_radius);

    // The disc test comes first, so a tap within both radii counts as center.
    always_comb begin
        int unsigned d2;
        d2 = 0;
        for (int dy = 0; dy < SPAN; dy++) begin
            row_csum[dy] = '0;
            row_rsum[dy] = '0;
            for (int dx = 0; dx < SPAN; dx++) begin
                d2 = csrf_pkg::tap_dist2(dy, dx);
                if (d2 <= 32'(rin2)) begin
                    row_csum[dy] = row_csum[dy] + ROWSUM_W'(r_win[dy][dx]);
                end else if (d2 <= 32'(csrf_pkg::RADIUS * csrf_pkg::RADIUS)) begin
                    row_rsum[dy] = row_rsum[dy] + ROWSUM_W'(r_win[dy][dx]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (rdy3) begin
            r_s3_valid <= r_s2_valid && r_s2_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_s2_valid) begin
            for (int dy = 0; dy < SPAN; dy++) begin
                r_s3_csum[dy] <= row_csum[dy];
                r_s3_rsum[dy] <= row_rsum[dy];
            end
            r_s3_crow <= r_s2_crow;
            r_s3_ccol <= r_s2_ccol;
            r_s3_last <= r_s2_last;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: window totals
    // ------------------------------------------------------------------------
    logic [TOT_W-1:0]  ctot;
    logic [TOT_W-1:0]  rtot;
    logic [TOT_W-1:0]  r_s4_ctot;
    logic [TOT_W-1:0]  r_s4_rtot;
    logic [ROW_W-1:0]  r_s4_crow;
    logic [CCOL_W-1:0] r_s4_ccol;
    logic              r_s4_last;

    always_comb begin
        ctot = '0;
        rtot = '0;
        for (int dy = 0; dy < SPAN; dy++) begin
            ctot = ctot + TOT_W'(r_s3_csum[dy]);
            rtot = rtot + TOT_W'(r_s3_rsum[dy]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (rdy4) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_s3_valid) begin
            r_s4_ctot <= ctot;
            r_s4_rtot <= rtot;
            r_s4_crow <= r_s3_crow;
            r_s4_ccol <= r_s3_ccol;
            r_s4_last <= r_s3_last;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: weighting
    // ------------------------------------------------------------------------
    logic signed [PROD_W-1:0] r_s5_cprod;
    logic signed [PROD_W-1:0] r_s5_rprod;
    logic [ROW_W-1:0]         r_s5_crow;
    logic [CCOL_W-1:0]        r_s5_ccol;
    logic                     r_s5_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (rdy5) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5 && r_s4_valid) begin
            r_s5_cprod <= r_center_weight * $signed({1'b0, r_s4_ctot});
            r_s5_rprod <= r_surround_weight * $signed({1'b0, r_s4_rtot});
            r_s5_crow  <= r_s4_crow;
            r_s5_ccol  <= r_s4_ccol;
            r_s5_last  <= r_s4_last;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: weighted sum
    // ------------------------------------------------------------------------
    logic signed [SUM_W-1:0] r_s6_sum;
    logic [ROW_W-1:0]        r_s6_crow;
    logic [CCOL_W-1:0]       r_s6_ccol;
    logic                    r_s6_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (rdy6) begin
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy6 && r_s5_valid) begin
            r_s6_sum  <= SUM_W'(r_s5_cprod) + SUM_W'(r_s5_rprod);
            r_s6_crow <= r_s5_crow;
            r_s6_ccol <= r_s5_ccol;
            r_s6_last <= r_s5_last;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 7: sign and magnitude
    // ------------------------------------------------------------------------
    logic              r_s7_neg;
    logic [ABS_W-1:0]  r_s7_abs;
    logic [SUM_W-1:0]  neg_sum;
    logic [ROW_W-1:0]  r_s7_crow;
    logic [CCOL_W-1:0] r_s7_ccol;
    logic              r_s7_last;

    assign neg_sum = -r_s6_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else if (rdy7) begin
            r_s7_valid <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy7 && r_s6_valid) begin
            r_s7_neg  <= r_s6_sum[SUM_W-1];
            r_s7_abs  <= r_s6_sum[SUM_W-1] ? neg_sum[ABS_W-1:0] : r_s6_sum[ABS_W-1:0];
            r_s7_crow <= r_s6_crow;
            r_s7_ccol <= r_s6_ccol;
            r_s7_last <= r_s6_last;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 8: quotient estimate by reciprocal multiply
    // ------------------------------------------------------------------------
    logic [MUL_W-1:0]  recip_prod;
    logic [ABS_W-1:0]  r_s8_quo0;
    logic [ABS_W-1:0]  r_s8_abs;
    logic              r_s8_neg;
    logic [ROW_W-1:0]  r_s8_crow;
    logic [CCOL_W-1:0] r_s8_ccol;
    logic              r_s8_last;

    assign recip_prod = MUL_W'(r_s7_abs) * MUL_W'(csrf_pkg::RECIP_K);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_valid <= 1'b0;
        end else if (rdy8) begin
            r_s8_valid <= r_s7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy8 && r_s7_valid) begin
            r_s8_quo0 <= ABS_W'(recip_prod >> csrf_pkg::RECIP_SH);
            r_s8_abs  <= r_s7_abs;
            r_s8_neg  <= r_s7_neg;
            r_s8_crow <= r_s7_crow;
            r_s8_ccol <= r_s7_ccol;
            r_s8_last <= r_s7_last;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 9: quotient correction, sign restore, output register
    // ------------------------------------------------------------------------
    logic [ABS_W-1:0]        rem;
    logic [ABS_W-1:0]        quo;
    logic [ABS_W-1:0]        quo_signed;
    logic signed [OUT_W-1:0] r_s9_value;
    logic [ROW_W-1:0]        r_s9_crow;
    logic [CCOL_W-1:0]       r_s9_ccol;
    logic                    r_s9_last;

    // The estimate is never above the true quotient and at most one below it.
    always_comb begin
        rem        = r_s8_abs - ABS_W'(r_s8_quo0 * ABS_W'(csrf_pkg::AREA));
        quo        = (rem >= ABS_W'(csrf_pkg::AREA)) ? r_s8_quo0 + ABS_W'(1) : r_s8_quo0;
        quo_signed = r_s8_neg ? -quo : quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_valid <= 1'b0;
        end else if (rdy9) begin
            r_s9_valid <= r_s8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy9 && r_s8_valid) begin
            r_s9_value <= $signed(quo_signed[OUT_W-1:0]);
            r_s9_crow  <= r_s8_crow;
            r_s9_ccol  <= r_s8_ccol;
            r_s9_last  <= r_s8_last;
        end
    end

    assign o_out_valid      = r_s9_valid;
    assign o_filtered_value = r_s9_value;
    assign o_center_row     = r_s9_crow;
    assign o_center_col     = r_s9_ccol;
    assign o_last_of_frame  = r_s9_last;

endmodule

// File: tb/sv/tb_center_surround_ring_filter_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_center_surround_ring_filter_core
// Streams grayscale frames through the center-surround ring filter and checks
// every filtered center, with its position and end-of-frame flag, against a
// pixel-by-pixel prediction of the weighted window sum divided by the area. Geometry
// and weights change between frame groups; both handshake sides idle at random.
// ---------------------------------------------------------------------------
module tb_center_surround_ring_filter_core;

    localparam int RADIUS     = csrf_pkg::RADIUS;
    localparam int MAX_WIDTH  = csrf_pkg::MAX_WIDTH;
    localparam int SPAN       = csrf_pkg::SPAN;
    localparam int LINES      = csrf_pkg::LINES;
    localparam int AREA       = csrf_pkg::AREA;
    localparam int PIX_W      = csrf_pkg::PIX_W;
    localparam int IW_W       = csrf_pkg::IW_W;
    localparam int IH_W       = csrf_pkg::IH_W;
    localparam int IR_W       = csrf_pkg::IR_W;
    localparam int WGT_W      = csrf_pkg::WGT_W;
    localparam int ROW_W      = csrf_pkg::ROW_W;
    localparam int CCOL_W     = csrf_pkg::CCOL_W;
    localparam int OUT_W      = csrf_pkg::OUT_W;
    localparam int CFG_IDX_W  = csrf_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = csrf_pkg::CFG_DATA_W;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 24;
    localparam int IDLE_PCT     = 36;
    localparam int RANDOM_ITEMS = 800;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd5;

    typedef enum int {PIX_RANDOM, PIX_ZERO, PIX_FULL, PIX_EXTREME} t_pix_mode;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic [ROW_W-1:0]        row;
        logic [CCOL_W-1:0]       col;
        logic                    last;
    } t_center_result;

    // Keeps its own copy of the line stores, window, counters and registers,
    // and the queue of centers still owed by the block.
    class ring_sum_scoreboard;
        logic [IW_W-1:0]         width_reg;
        logic [IH_W-1:0]         height_reg;
        logic [IR_W-1:0]         inner_reg;
        logic signed [WGT_W-1:0] center_w;
        logic signed [WGT_W-1:0] surround_w;
        logic [PIX_W-1:0]        line_mem [LINES][MAX_WIDTH];
        logic [PIX_W-1:0]        win [SPAN][SPAN];
        int unsigned             row_pos;
        int unsigned             col_pos;
        t_center_result          expected_centers[$];
        int unsigned             fail_count;

        function new();
            width_reg    = csrf_pkg::RST_IMAGE_WIDTH;
            height_reg   = csrf_pkg::RST_IMAGE_HEIGHT;
            inner_reg    = csrf_pkg::RST_INNER_RADIUS;
            center_w     = csrf_pkg::RST_CENTER_WEIGHT;
            surround_w   = csrf_pkg::RST_SURROUND_WEIGHT;
            row_pos      = 0;
            col_pos      = 0;
            fail_count   = 0;
            foreach (line_mem[i, j]) line_mem[i][j] = '0;
            foreach (win[i, j]) win[i][j] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                csrf_pkg::CFG_IMAGE_WIDTH:     width_reg  = data[IW_W-1:0];
                csrf_pkg::CFG_IMAGE_HEIGHT:    height_reg = data[IH_W-1:0];
                csrf_pkg::CFG_INNER_RADIUS:    inner_reg  = data[IR_W-1:0];
                csrf_pkg::CFG_CENTER_WEIGHT:   center_w   = data[WGT_W-1:0];
                csrf_pkg::CFG_SURROUND_WEIGHT: surround_w = data[WGT_W-1:0];
                default: ;
            endcase
        endfunction

        function void push_pixel(logic [PIX_W-1:0] pix, logic first);
            int unsigned      eff_w;
            int unsigned      r;
            int unsigned      c;
            int unsigned      ci;
            int               oy;
            int               ox;
            int               d2;
            int               rin2;
            longint           acc;
            logic [PIX_W-1:0] col_px [SPAN];
            t_center_result   res;

            eff_w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
            if (first) begin
                row_pos = 0;
                col_pos = 0;
            end
            r  = row_pos;
            c  = col_pos;
            ci = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;

            // The column read from the line stores sits on top of the new pixel,
            // and each store line takes the pixel from the line below it.
            for (int dy = 0; dy < LINES; dy++) col_px[dy] = line_mem[dy][ci];
            col_px[LINES] = pix;
            for (int dy = 0; dy < LINES; dy++) line_mem[dy][ci] = col_px[dy + 1];

            for (int dy = 0; dy < SPAN; dy++) begin
                for (int dx = 0; dx < SPAN - 1; dx++) win[dy][dx] = win[dy][dx + 1];
                win[dy][SPAN - 1] = col_px[dy];
            end

            if (r >= LINES && c >= LINES) begin
                acc  = 0;
                rin2 = int'(inner_reg) * int'(inner_reg);
                for (int dy = 0; dy < SPAN; dy++) begin
                    for (int dx = 0; dx < SPAN; dx++) begin
                        oy = dy - RADIUS;
                        ox = dx - RADIUS;
                        d2 = oy * oy + ox * ox;
                        if (d2 <= rin2) begin
                            acc += longint'(win[dy][dx]) * longint'(center_w);
                        end else if (d2 <= RADIUS * RADIUS) begin
                            acc += longint'(win[dy][dx]) * longint'(surround_w);
                        end
                    end
                end
                acc       = acc / AREA;
                res.value = acc[OUT_W-1:0];
                res.row   = ROW_W'(r - RADIUS);
                res.col   = CCOL_W'(c - RADIUS);
                res.last  = (r + 1 >= height_reg) && (c + 1 >= eff_w);
                expected_centers.push_back(res);
            end

            if (c + 1 >= eff_w) begin
                col_pos = 0;
                row_pos = (r + 1 >= height_reg) ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void flag(string what, logic signed [31:0] want, logic signed [31:0] got);
            fail_count++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        endfunction

        function void check_result(logic signed [OUT_W-1:0] value, logic [ROW_W-1:0] row,
                                   logic [CCOL_W-1:0] col, logic last);
            t_center_result want;
            if (expected_centers.size() == 0) begin
                fail_count++;
                $display("%0t: result with none outstanding, expected nothing, got %0d",
                         $time, value);
                return;
            end
            want = expected_centers.pop_front();
            if (value !== want.value) flag("filtered_value", want.value, value);
            if (row !== want.row) flag("center_row", want.row, row);
            if (col !== want.col) flag("center_col", want.col, col);
            if (last !== want.last) flag("last_of_frame", want.last, last);
        endfunction
    endclass

    logic                      i_clk            = 1'b0;
    logic                      i_rst_n          = 1'b0;
    logic                      i_cfg_valid      = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data       = '0;
    logic                      i_in_valid       = 1'b0;
    logic                      o_in_stall;
    logic [PIX_W-1:0]          i_pixel          = '0;
    logic                      i_first_of_frame = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall      = 1'b0;
    logic signed [OUT_W-1:0]   o_filtered_value;
    logic [ROW_W-1:0]          o_center_row;
    logic [CCOL_W-1:0]         o_center_col;
    logic                      o_last_of_frame;

    int                        idle_pct    = IDLE_PCT;
    int unsigned               cycle_count = 0;
    ring_sum_scoreboard        board;

    center_surround_ring_filter_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pixel          (i_pixel),
        .i_first_of_frame (i_first_of_frame),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_filtered_value (o_filtered_value),
        .o_center_row     (o_center_row),
        .o_center_col     (o_center_col),
        .o_last_of_frame  (o_last_of_frame)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                board.push_pixel(i_pixel, i_first_of_frame);
            end
            if (o_out_valid && !i_out_stall) begin
                board.check_result(o_filtered_value, o_center_row, o_center_col,
                                   o_last_of_frame);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("center_surround_ring_filter_core: mismatch");
            $finish;
        end
    end

    // Leaves valid high after the request is taken; the caller lowers it.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic first);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_pixel          <= pix;
        i_first_of_frame <= first;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_stream(input int unsigned count, input t_pix_mode mode,
                               input int unsigned restart_odds);
        logic [PIX_W-1:0] pix;
        logic             first;
        for (int unsigned n = 0; n < count; n++) begin
            case (mode)
                PIX_ZERO:    pix = '0;
                PIX_FULL:    pix = {PIX_W{1'b1}};
                PIX_EXTREME: pix = $urandom_range(1) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
                default:     pix = PIX_W'($urandom);
            endcase
            first = (n == 0) || (restart_odds != 0 && $urandom_range(restart_odds - 1) == 0);
            send_pixel(pix, first);
        end
        i_in_valid <= 1'b0;
    endtask

    // Border pixels give no result, so the pipeline may still be busy when the
    // last center arrives; the extra cycles cover that before any register write.
    task automatic settle();
        while (board.expected_centers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // Unused upper data bits carry random values; the registers keep only
    // their own width.
    task automatic program_all(input logic [IW_W-1:0] w, input logic [IH_W-1:0] h,
                               input logic [IR_W-1:0] ir, input logic [WGT_W-1:0] cw,
                               input logic [WGT_W-1:0] sw);
        program_reg(csrf_pkg::CFG_IMAGE_WIDTH, {(CFG_DATA_W - IW_W)'($urandom), w});
        program_reg(csrf_pkg::CFG_IMAGE_HEIGHT, {(CFG_DATA_W - IH_W)'($urandom), h});
        program_reg(csrf_pkg::CFG_INNER_RADIUS, {(CFG_DATA_W - IR_W)'($urandom), ir});
        program_reg(csrf_pkg::CFG_CENTER_WEIGHT, cw);
        program_reg(csrf_pkg::CFG_SURROUND_WEIGHT, sw);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [WGT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return WGT_W'($urandom);
        endcase
    endfunction

    initial begin
        int unsigned random_items;
        int unsigned w;
        int unsigned h;
        int unsigned count;
        int unsigned pick;

        board = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default radius and weights on a narrow frame of seven rows.
        program_reg(csrf_pkg::CFG_IMAGE_WIDTH, CFG_DATA_W'(16));
        program_reg(csrf_pkg::CFG_IMAGE_HEIGHT, CFG_DATA_W'(SPAN));
        i_cfg_valid <= 1'b0;
        send_stream(16 * SPAN, PIX_RANDOM, 0);
        settle();

        // Smallest frames with a single center, at the weight extremes and the default weights.
        program_all(SPAN, SPAN, 3, 16'h7FFF, 16'h7FFF);
        send_stream(AREA, PIX_FULL, 0);
        settle();
        program_all(SPAN, SPAN, 3, 16'h8000, 16'h8000);
        send_stream(AREA, PIX_FULL, 0);
        settle();
        program_all(SPAN, SPAN, 0, 16'h7FFF, 16'h8000);
        send_stream(2 * AREA, PIX_EXTREME, 0);
        settle();
        program_reg(CFG_SPARE_INDEX, 16'hFFFF);
        program_all(SPAN, SPAN, 2, 16'hFF00, 16'h0600);
        send_stream(AREA, PIX_ZERO, 0);
        settle();

        // A width or height of zero or one pins its counter, so no centers.
        for (int k = 0; k < 4; k++) begin
            program_all((k < 2) ? k : 9, (k < 2) ? SPAN : k - 2, $urandom_range(3),
                        pick_weight(), pick_weight());
            send_stream(30, PIX_RANDOM, 0);
            settle();
        end

        // This frame runs without idling on either side.
        idle_pct = 0;
        program_all(11'd40, 12'd12, 2, pick_weight(), pick_weight());
        send_stream(40 * 12, PIX_RANDOM, 0);
        settle();
        idle_pct = IDLE_PCT;

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 80) w = $urandom_range(16, SPAN);
            else if (pick < 90) w = $urandom_range(40, 17);
            else if (pick < 95) w = $urandom_range(SPAN - 1, 2);
            else w = $urandom_range(1);
            pick = $urandom_range(99);
            if (pick < 85) h = $urandom_range(10, SPAN);
            else if (pick < 95) h = $urandom_range(SPAN - 1, 2);
            else h = $urandom_range(1);
            program_all(w, h, $urandom_range(3), pick_weight(), pick_weight());
            if (w >= SPAN && h >= SPAN) count = w * h * $urandom_range(2, 1);
            else count = $urandom_range(40, 10);
            send_stream(count, ($urandom_range(9) == 0) ? PIX_EXTREME : PIX_RANDOM,
                        ($urandom_range(3) == 0) ? 150 : 0);
            settle();
            random_items += count;
        end

        if (board.fail_count == 0) begin
            $display("center_surround_ring_filter_core: match");
        end else begin
            $display("center_surround_ring_filter_core: mismatch");
        end
        $finish;
    end

endmodule
